@@ rtl/biquad_filter_coefficient_ramp_unit_defines.svh @@
// Assertion macros used by the checker module of this block.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef BIQUAD_FILTER_COEFFICIENT_RAMP_UNIT_DEFINES_SVH
`define BIQUAD_FILTER_COEFFICIENT_RAMP_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BQR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BQR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/bqr_pkg.sv @@
package bqr_pkg;

  localparam int unsigned SAMPLE_W  = 32;
  localparam int unsigned COEF_W    = 40;
  localparam int unsigned INC_W     = COEF_W + 1;
  localparam int unsigned ACC_W     = 64;
  localparam int unsigned FRAC_BITS = 32;
  localparam int unsigned STEPS_W   = 16;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned NUM_COEF   = 5;
  localparam int unsigned COEF_IDX_W = $clog2(NUM_COEF);

  localparam int unsigned RAMP_COUNT_BITS_DEF = 16;

  // The divider produces one quotient bit per cycle.
  localparam int unsigned DIV_STEPS = INC_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // Reset value of the coefficients: b0 is unity in Q32, the rest zero.
  localparam logic signed [COEF_W-1:0] COEF_RST [NUM_COEF] = '{
    40'sh01_0000_0000, 40'sh0, 40'sh0, 40'sh0, 40'sh0
  };

  typedef enum logic [OP_W-1:0] {
    OP_FILTER = 2'd0,
    OP_APPLY  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_B0    = 3'd0,
    CFG_B1    = 3'd1,
    CFG_B2    = 3'd2,
    CFG_A1    = 3'd3,
    CFG_A2    = 3'd4,
    CFG_STEPS = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic clr;  // start a new sum
    logic mul;  // operands valid this cycle
  } mac_ctl_t;

endpackage

@@ rtl/bqr_mac.sv @@
module bqr_mac (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  bqr_pkg::mac_ctl_t                     ctl,
  input  logic signed [bqr_pkg::COEF_W-1:0]     coef,
  input  logic signed [bqr_pkg::SAMPLE_W-1:0]   term,
  output logic signed [bqr_pkg::SAMPLE_W-1:0]   acc_hi
);
  import bqr_pkg::*;

  logic signed [COEF_W+SAMPLE_W-1:0] prod;
  logic [ACC_W-1:0]                  prod_r;
  logic [ACC_W-1:0]                  acc_r;
  logic                              prod_vld_r;

  // Only the low 64 bits of each product matter, the sum wraps modulo 2^64.
  assign prod = coef * term;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= ctl.mul;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod_r <= prod[ACC_W-1:0];
    end
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + prod_r;
    end
  end

  assign acc_hi = signed'(acc_r[ACC_W-1 -: SAMPLE_W]);

endmodule

@@ rtl/bqr_div.sv @@
module bqr_div #(
  parameter int unsigned DIVISOR_W = bqr_pkg::RAMP_COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [bqr_pkg::INC_W-1:0]   dividend,
  input  logic [DIVISOR_W-1:0]               divisor,
  output logic                               done,
  output logic signed [bqr_pkg::INC_W-1:0]   quotient
);
  import bqr_pkg::*;

  logic [INC_W-1:0]     dq_r;
  logic [INC_W-1:0]     dq_nxt;
  logic [DIVISOR_W-1:0] rem_r;
  logic [DIVISOR_W-1:0] rem_nxt;
  logic [DIVISOR_W-1:0] dsr_r;
  logic                 neg_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 done_r;
  logic [DIVISOR_W:0]   rem_sh;
  logic [DIVISOR_W:0]   rem_dif;
  logic                 ge;
  logic [INC_W-1:0]     mag;

  // Restoring division on magnitudes; the sign is applied afterwards so
  // that the quotient truncates toward zero.
  assign mag     = dividend[INC_W-1] ? INC_W'(-dividend) : INC_W'(dividend);
  assign rem_sh  = {rem_r, dq_r[INC_W-1]};
  assign rem_dif = rem_sh - {1'b0, dsr_r};
  assign ge      = rem_sh >= {1'b0, dsr_r};
  assign rem_nxt = ge ? rem_dif[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
  assign dq_nxt  = {dq_r[INC_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= DIV_CNT_W'(DIV_STEPS);
      end else if (cnt_r != '0) begin
        cnt_r  <= cnt_r - 1'b1;
        done_r <= cnt_r == DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= mag;
      rem_r <= '0;
      dsr_r <= divisor;
      neg_r <= dividend[INC_W-1];
    end else if (cnt_r != '0) begin
      dq_r  <= dq_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? signed'(-dq_r) : signed'(dq_r);

endmodule

@@ rtl/biquad_filter_coefficient_ramp_unit.sv @@
// Direct-form-1 biquad on signed 32-bit samples with signed Q32 coefficients
// that can glide to new targets over a programmable number of samples. A
// filter transfer (op 0) returns one output sample, the top 32 bits of the
// 64-bit wrapped sum b0*x0 + b1*x1 + b2*x2 + a1*y1 + a2*y2, where a1 and a2
// are programmed already negated. An apply transfer (op 1) loads the
// programmed targets: at once when ramp_steps is zero, otherwise it computes
// per-coefficient increments (target minus current, divided by the step
// count and truncated toward zero) which are added after each of the next
// ramp_steps filtered samples. A clear transfer (op 2) zeroes the histories,
// the coefficients and the increments and stops any glide; op 3 is ignored.
// Only filter transfers produce an output transfer. All products go through
// one shared 40x32 multiplier, one per cycle; a filter item passes from
// input transfer to output register through an accept state, a multiply
// state for the five products, an accumulate state and a write state, and
// waits there only if the previous result has not been taken yet. An apply
// with a nonzero step count runs the five increment divisions one after
// another on a shared bit-serial divider of 41 steps. Clear, an immediate
// apply and op 3 complete in their accept cycle. Input is refused while an
// item is in progress; configuration writes are always accepted and must only
// be issued while the block is idle.
module biquad_filter_coefficient_ramp_unit #(
  parameter int unsigned RAMP_COUNT_BITS = bqr_pkg::RAMP_COUNT_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [bqr_pkg::OP_W-1:0]               in_op,
  input  logic signed [bqr_pkg::SAMPLE_W-1:0]    in_sample_in,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [bqr_pkg::SAMPLE_W-1:0]    out_sample_out,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [bqr_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [bqr_pkg::COEF_W-1:0]             cfg_data
);
  import bqr_pkg::*;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_MUL    = 6'b000010,
    S_DRAIN  = 6'b000100,
    S_OUT    = 6'b001000,
    S_DSTART = 6'b010000,
    S_DWAIT  = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Programmed targets and glide length.
  logic signed [COEF_W-1:0] tgt_r [NUM_COEF];
  logic [STEPS_W-1:0]       steps_cfg_r;
  logic [RAMP_COUNT_BITS-1:0] steps;

  // Filter state.
  logic signed [COEF_W-1:0]   coef_r [NUM_COEF];
  logic signed [INC_W-1:0]    inc_r  [NUM_COEF];
  logic [RAMP_COUNT_BITS-1:0] ramp_r;
  logic signed [SAMPLE_W-1:0] x0_r;
  logic signed [SAMPLE_W-1:0] x1_r;
  logic signed [SAMPLE_W-1:0] x2_r;
  logic signed [SAMPLE_W-1:0] y1_r;
  logic signed [SAMPLE_W-1:0] y2_r;

  // Which coefficient the shared units work on.
  logic [COEF_IDX_W-1:0] idx_r;
  logic                  last_idx;

  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;

  logic                       in_fire;
  logic                       out_load;
  mac_ctl_t                   mac_ctl;
  logic signed [SAMPLE_W-1:0] term;
  logic signed [SAMPLE_W-1:0] acc_hi;
  logic                       div_start;
  logic                       div_done;
  logic signed [INC_W-1:0]    diff;
  logic signed [INC_W-1:0]    div_q;

  // The step count is masked to the counter width before use.
  assign steps    = RAMP_COUNT_BITS'(steps_cfg_r);
  assign last_idx = idx_r == COEF_IDX_W'(NUM_COEF - 1);
  assign in_ready = state_r == S_IDLE;
  assign in_fire  = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Distance from the present coefficient to its target, one bit wider.
  assign diff = {tgt_r[idx_r][COEF_W-1], tgt_r[idx_r]}
              - {coef_r[idx_r][COEF_W-1], coef_r[idx_r]};

  // Multiplier operand matching the coefficient being multiplied.
  always_comb begin
    case (idx_r)
      COEF_IDX_W'(0): term = x0_r;
      COEF_IDX_W'(1): term = x1_r;
      COEF_IDX_W'(2): term = x2_r;
      COEF_IDX_W'(3): term = y1_r;
      COEF_IDX_W'(4): term = y2_r;
      default:        term = '0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    mac_ctl   = '0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_op)
            OP_FILTER: begin
              mac_ctl.clr = 1'b1;
              state_nxt   = S_MUL;
            end
            OP_APPLY: begin
              if (steps != '0) begin
                state_nxt = S_DSTART;
              end
            end
            default: ;
          endcase
        end
      end
      S_MUL: begin
        mac_ctl.mul = 1'b1;
        if (last_idx) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // The result register must be free or emptying this cycle.
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DSTART: begin
        div_start = 1'b1;
        state_nxt = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_done) begin
          state_nxt = last_idx ? S_IDLE : S_DSTART;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ramp_r      <= '0;
      idx_r       <= '0;
      steps_cfg_r <= '0;
      x1_r        <= '0;
      x2_r        <= '0;
      y1_r        <= '0;
      y2_r        <= '0;
      for (int i = 0; i < NUM_COEF; i++) begin
        tgt_r[i]  <= COEF_RST[i];
        coef_r[i] <= COEF_RST[i];
        inc_r[i]  <= '0;
      end
    end else begin
      state_r <= state_nxt;

      if (cfg_valid) begin
        unique case (cfg_index) inside
          CFG_B0, CFG_B1, CFG_B2, CFG_A1, CFG_A2: begin
            tgt_r[COEF_IDX_W'(cfg_index)] <= signed'(cfg_data);
          end
          CFG_STEPS: steps_cfg_r <= cfg_data[STEPS_W-1:0];
          default: ;
        endcase
      end

      // The result register fills on a load and empties on an output transfer.
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (in_fire) begin
        unique case (in_op)
          OP_FILTER: begin
            idx_r <= '0;
          end
          OP_APPLY: begin
            idx_r <= '0;
            if (steps == '0) begin
              ramp_r <= '0;
              for (int i = 0; i < NUM_COEF; i++) begin
                coef_r[i] <= tgt_r[i];
                inc_r[i]  <= '0;
              end
            end
          end
          OP_CLEAR: begin
            ramp_r <= '0;
            x1_r   <= '0;
            x2_r   <= '0;
            y1_r   <= '0;
            y2_r   <= '0;
            for (int i = 0; i < NUM_COEF; i++) begin
              coef_r[i] <= '0;
              inc_r[i]  <= '0;
            end
          end
          default: ;
        endcase
      end

      if (mac_ctl.mul && !last_idx) begin
        idx_r <= idx_r + 1'b1;
      end

      // Result goes out; histories shift and a running glide advances.
      if (out_load) begin
        x2_r <= x1_r;
        x1_r <= x0_r;
        y2_r <= y1_r;
        y1_r <= acc_hi;
        if (ramp_r != '0) begin
          ramp_r <= ramp_r - 1'b1;
          for (int i = 0; i < NUM_COEF; i++) begin
            coef_r[i] <= coef_r[i] + inc_r[i][COEF_W-1:0];
          end
        end
      end

      if (state_r == S_DWAIT && div_done) begin
        inc_r[idx_r] <= div_q;
        if (last_idx) begin
          ramp_r <= steps;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
    end
  end

  // Sample and result payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      x0_r <= in_sample_in;
    end
    if (out_load) begin
      out_sample_r <= acc_hi;
    end
  end

  bqr_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .coef   (coef_r[idx_r]),
    .term   (term),
    .acc_hi (acc_hi)
  );

  bqr_div #(
    .DIVISOR_W (RAMP_COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (diff),
    .divisor  (steps),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

endmodule

@@ rtl/bqr_chk.sv @@
`include "biquad_filter_coefficient_ramp_unit_defines.svh"

module bqr_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic [bqr_pkg::OP_W-1:0]            in_op,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [bqr_pkg::SAMPLE_W-1:0] out_sample_out,
  input logic                                cfg_valid,
  input logic                                cfg_ready
);
  import bqr_pkg::*;

  // A waiting result is neither dropped nor overwritten.
  `BQR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_sample_out), "result changed while stalled")

  // A filter item occupies the shared multiplier, so input is refused once it is taken.
  `BQR_ASSERT_NXT(a_filter_busy, in_valid && in_ready && in_op == OP_FILTER, !in_ready, "input taken during a filter item")

  // Clear completes in its accept cycle.
  `BQR_ASSERT_NXT(a_clear_fast, in_valid && in_ready && in_op == OP_CLEAR, in_ready, "clear did not finish in one cycle")

  // A new result only appears at the end of a filter item, and configuration writes are never stalled.
  `BQR_ASSERT_IMP(a_out_from_item, $rose(out_valid) || (cfg_valid && !cfg_ready), $past(!in_ready) && cfg_ready, "result without a filter item or config stalled")

endmodule

bind biquad_filter_coefficient_ramp_unit bqr_chk u_bqr_chk (.*);

@@ tb/biquad_filter_coefficient_ramp_unit_tb.sv @@
`timescale 1ns / 1ps

module biquad_filter_coefficient_ramp_unit_tb;
  import bqr_pkg::*;

  // The op encoding leaves one code unused; the block must swallow it silently.
  localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;

  // Q32 constants used to build coefficient settings.
  localparam longint Q32_ONE  = 64'sh0000_0001_0000_0000;
  localparam longint COEF_MAX = 64'sh0000_007F_FFFF_FFFF;
  localparam longint COEF_MIN = -64'sh0000_0080_0000_0000;

  // An apply with a nonzero step count keeps the block busy without producing
  // an output, so every settle pause must outlast it.
  localparam int SETTLE_CYCLES    = 300;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int NUM_PHASES       = 6;
  localparam int PHASE_ITEMS      = 72;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                       in_valid     = 1'b0;
  logic                       in_ready;
  logic [OP_W-1:0]            in_op        = OP_FILTER;
  logic signed [SAMPLE_W-1:0] in_sample_in = '0;
  logic                       out_valid;
  logic                       out_ready    = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  logic                       cfg_valid    = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index    = CFG_B0;
  logic [COEF_W-1:0]          cfg_data     = '0;

  // Shared knobs. burst_mode removes idling on both sides so that stretches
  // of back-to-back transfers occur; hold_results asks the result sink for one
  // long stall.
  logic burst_mode   = 1'b0;
  logic hold_results = 1'b0;
  int   error_count  = 0;
  int   cycle_count  = 0;

  // Filter state as the block should hold it. Coefficients and increments are
  // kept sign-extended in 64-bit integers; wrapping to 40 bits happens on the
  // glide update.
  longint                coef_now    [NUM_COEF];
  longint                coef_inc    [NUM_COEF];
  logic [STEPS_W-1:0]    glide_left;
  int                    x_hist      [2];
  int                    y_hist      [2];
  logic [COEF_W-1:0]     coef_target [NUM_COEF];
  logic [STEPS_W-1:0]    glide_steps;

  // Output samples still owed by the block, oldest first.
  logic signed [SAMPLE_W-1:0] expected_samples [$];
  logic signed [SAMPLE_W-1:0] want_sample;

  always #1 clk = ~clk;

  biquad_filter_coefficient_ramp_unit i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_sample_in  (in_sample_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sample_out(out_sample_out),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Filter model
  // ---------------------------------------------------------------------------

  function automatic longint wrap_coef(longint v);
    logic signed [COEF_W-1:0] t;
    t = v[COEF_W-1:0];
    return longint'(t);
  endfunction

  task automatic reset_biquad_model();
    int i;
    for (i = 0; i < NUM_COEF; i++) begin
      coef_now[i]    = 0;
      coef_inc[i]    = 0;
      coef_target[i] = '0;
    end
    coef_now[0]    = Q32_ONE;
    coef_target[0] = Q32_ONE[COEF_W-1:0];
    glide_left     = '0;
    glide_steps    = '0;
    x_hist         = '{0, 0};
    y_hist         = '{0, 0};
  endtask

  // Applies one accepted input transfer to the model and queues the output
  // sample that a filter operation must produce.
  task automatic advance_biquad_model(input logic [OP_W-1:0] op,
                                      input logic signed [SAMPLE_W-1:0] smp);
    longint terms [NUM_COEF];
    longint acc;
    longint target;
    int     y0;
    int     i;
    case (op)
      OP_FILTER: begin
        terms[0] = longint'(smp);
        terms[1] = x_hist[0];
        terms[2] = x_hist[1];
        terms[3] = y_hist[0];
        terms[4] = y_hist[1];
        // The products and the sum wrap modulo 2^64, as 64-bit integers do.
        acc = 0;
        for (i = 0; i < NUM_COEF; i++) acc += coef_now[i] * terms[i];
        y0 = int'(acc >>> FRAC_BITS);
        y_hist[1] = y_hist[0];
        y_hist[0] = y0;
        x_hist[1] = x_hist[0];
        x_hist[0] = smp;
        // The glide step follows the sample, so the output above still used
        // the coefficients from before this update.
        if (glide_left != '0) begin
          glide_left = glide_left - 1'b1;
          for (i = 0; i < NUM_COEF; i++) coef_now[i] = wrap_coef(coef_now[i] + coef_inc[i]);
        end
        expected_samples.push_back(y0);
      end
      OP_APPLY: begin
        // A new glide always starts from the present coefficients, even if
        // an earlier glide has not finished. Division truncates toward zero.
        for (i = 0; i < NUM_COEF; i++) begin
          target = longint'($signed(coef_target[i]));
          if (glide_steps == '0) begin
            coef_now[i] = target;
            coef_inc[i] = 0;
          end else begin
            coef_inc[i] = (target - coef_now[i]) / longint'(glide_steps);
          end
        end
        glide_left = glide_steps;
      end
      OP_CLEAR: begin
        for (i = 0; i < NUM_COEF; i++) begin
          coef_now[i] = 0;
          coef_inc[i] = 0;
        end
        glide_left = '0;
        x_hist     = '{0, 0};
        y_hist     = '{0, 0};
      end
      default: begin
        // The unused op code leaves every piece of state alone.
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Random value sources
  // ---------------------------------------------------------------------------

  // Mostly short gaps with now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom;
    if (r < 85) return $urandom_range(0, 2000) - 1000;
    case ($urandom_range(0, 3))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return -32'sd1;
      default: return 32'sd0;
    endcase
  endfunction

  // Coefficients are mostly below one in magnitude in Q32, so that the glides
  // and outputs stay readable, with full-range and extreme values mixed in.
  function automatic logic [COEF_W-1:0] pick_coef();
    logic [63:0] raw;
    longint      c;
    int          r;
    raw = {$urandom, $urandom};
    r   = $urandom_range(0, 99);
    if (r < 35)      c = longint'($signed(raw[31:0]));
    else if (r < 55) c = longint'($signed(raw[31:0])) <<< 1;
    else if (r < 75) c = longint'($signed(raw[COEF_W-1:0]));
    else if (r < 85) begin
      case ($urandom_range(0, 3))
        0:       c = COEF_MAX;
        1:       c = COEF_MIN;
        2:       c = Q32_ONE;
        default: c = -Q32_ONE;
      endcase
    end else c = 0;
    return c[COEF_W-1:0];
  endfunction

  // Step counts favor short glides; a few carry junk above bit 15, which the
  // block must mask off.
  function automatic logic [COEF_W-1:0] pick_steps();
    logic [63:0] raw;
    int          r;
    raw = {$urandom, $urandom};
    r   = $urandom_range(0, 99);
    if (r < 30) return '0;
    if (r < 70) return $urandom_range(1, 8);
    if (r < 85) return $urandom_range(9, 300);
    if (r < 95) return $urandom_range(0, 65535);
    return raw[COEF_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------

  // Offers one input transfer and updates the model once it is taken. Valid
  // stays high across back-to-back items; a gap lowers it first.
  task automatic send_item(input logic [OP_W-1:0] op,
                           input logic signed [SAMPLE_W-1:0] smp);
    int gap;
    gap = burst_mode ? 0 : pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_sample_in <= smp;
    do @(posedge clk); while (!in_ready);
    advance_biquad_model(op, smp);
  endtask

  // Register writes are only issued from a settled, idle block.
  task automatic write_reg(input cfg_idx_t idx, input logic [COEF_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_STEPS) glide_steps = data[STEPS_W-1:0];
    else coef_target[idx] = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stops offering input, waits for every owed output, then gives a pending
  // apply with its divider pass time to finish.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result sink: random stalls, or one long hold when a test requests it.
  initial begin : result_sink
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_results) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        hold_results = 1'b0;
      end else if (stall != 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        stall = burst_mode ? 0 : pick_gap();
      end
    end
  end

  // Every output transfer must match the oldest owed sample.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_samples.size() == 0) begin
        $error("unexpected output transfer: sample_out actual %0d", out_sample_out);
        error_count++;
      end else begin
        want_sample = expected_samples.pop_front();
        if (out_sample_out !== want_sample) begin
          $error("sample_out mismatch: expected %0d, actual %0d", want_sample,
                 out_sample_out);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Out of reset b0 is unity and the rest zero, so the filter is a wire. The
  // unused op code in the middle must not disturb that.
  task automatic test_passthrough_after_reset();
    send_item(OP_FILTER, 32'sd0);
    send_item(OP_FILTER, 32'sh7FFF_FFFF);
    send_item(OP_FILTER, 32'sh8000_0000);
    send_item(OP_IGNORED, 32'sh5A5A_5A5A);
    send_item(OP_FILTER, -32'sd1);
    send_item(OP_FILTER, 32'sd1);
    send_item(OP_FILTER, 32'sd12345);
    settle();
  endtask

  // Zero steps: the extreme targets take effect at once, and the extreme
  // samples drive the 64-bit sum through its wrap.
  task automatic test_immediate_load();
    write_reg(CFG_B0, COEF_MAX[COEF_W-1:0]);
    write_reg(CFG_B1, COEF_MIN[COEF_W-1:0]);
    write_reg(CFG_B2, 40'h01_0000_0000);
    write_reg(CFG_A1, 40'hFF_8000_0000);
    write_reg(CFG_A2, 40'h00_4000_0000);
    write_reg(CFG_STEPS, '0);
    send_item(OP_APPLY, 32'sd0);
    send_item(OP_FILTER, 32'sh8000_0000);
    send_item(OP_FILTER, 32'sh7FFF_FFFF);
    send_item(OP_FILTER, -32'sd1);
    settle();
  endtask

  // A three-sample glide with junk above the step field. The small odd and
  // negative targets exercise truncation toward zero. The second apply
  // restarts the glide from wherever the coefficients stand, and the last
  // samples run past its end.
  task automatic test_coefficient_glide();
    write_reg(CFG_B0, 40'hFF_0000_0000);
    write_reg(CFG_B1, 40'h00_8000_0000);
    write_reg(CFG_B2, 40'h00_0000_0007);
    write_reg(CFG_A1, 40'h00_2000_0001);
    write_reg(CFG_A2, 40'hFF_FFFF_FFFB);
    write_reg(CFG_STEPS, 40'hA5_0000_0003);
    send_item(OP_APPLY, 32'sd0);
    send_item(OP_FILTER, 32'sd1000);
    send_item(OP_FILTER, -32'sd70000);
    send_item(OP_APPLY, 32'sd0);
    send_item(OP_FILTER, 32'sh4000_0000);
    send_item(OP_FILTER, 32'sh7FFF_FFFF);
    send_item(OP_FILTER, 32'sh8000_0000);
    send_item(OP_FILTER, 32'sd3);
    settle();
  endtask

  // The largest step count: tiny increments that keep running.
  task automatic test_longest_glide();
    write_reg(CFG_B0, COEF_MAX[COEF_W-1:0]);
    write_reg(CFG_STEPS, 40'h00_0000_FFFF);
    send_item(OP_APPLY, 32'sd0);
    send_item(OP_FILTER, 32'sh1234_5678);
    send_item(OP_FILTER, -32'sh0765_4321);
    settle();
  endtask

  // Clear in the middle of the long glide: everything goes to zero, the
  // glide stops, and the output stays zero whatever comes in.
  task automatic test_clear();
    send_item(OP_CLEAR, 32'sh7FFF_FFFF);
    send_item(OP_FILTER, 32'sh7FFF_FFFF);
    send_item(OP_FILTER, 32'sh8000_0000);
    settle();
  endtask

  // The sink holds off for a long stretch while the source keeps offering
  // filter items back to back, so the output register fills and the block
  // has to refuse input until the sink lets go.
  task automatic test_output_backpressure();
    int n;
    write_reg(CFG_B0, 40'h00_C000_0000);
    write_reg(CFG_A1, 40'h00_4000_0000);
    write_reg(CFG_STEPS, 40'd4);
    send_item(OP_APPLY, 32'sd0);
    burst_mode   = 1'b1;
    hold_results = 1'b1;
    for (n = 0; n < 12; n++) send_item(OP_FILTER, pick_sample());
    burst_mode = 1'b0;
    settle();
  endtask

  // Each phase programs a fresh random setting, applies it, and then runs a
  // mostly-filter stream with applies (often landing inside a running glide),
  // occasional clears and the odd unused op. Some phases run without idling.
  task automatic test_random_programs();
    int              phase;
    int              n;
    int              r;
    logic [OP_W-1:0] op;
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      burst_mode = (phase % 3 == 1);
      write_reg(CFG_B0, pick_coef());
      write_reg(CFG_B1, pick_coef());
      write_reg(CFG_B2, pick_coef());
      write_reg(CFG_A1, pick_coef());
      write_reg(CFG_A2, pick_coef());
      write_reg(CFG_STEPS, pick_steps());
      send_item(OP_APPLY, $urandom);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 84)      op = OP_FILTER;
        else if (r < 92) op = OP_APPLY;
        else if (r < 96) op = OP_CLEAR;
        else             op = OP_IGNORED;
        send_item(op, pick_sample());
      end
      settle();
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    reset_biquad_model();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_passthrough_after_reset();
    test_immediate_load();
    test_coefficient_glide();
    test_longest_glide();
    test_clear();
    test_output_backpressure();
    test_random_programs();

    if (error_count == 0 && expected_samples.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
